// ===== hdl/okbd_pkg.sv =====
// ----------------------------------------------------------------------------
// okbd_pkg: shared types and constants for the offset-keyed block decryptor
// Holds the transfer payload types, the rotation table and the rotate helpers.
// ----------------------------------------------------------------------------
package okbd_pkg;

   // Number of key registers and the width of the register address.
   localparam int unsigned NumKeys   = 4;
   localparam int unsigned AddrWidth = 4;

   // Input transfer payload.
   typedef struct packed {
      logic [31:0] block_offset;
      logic [63:0] cipher_low;
      logic [63:0] cipher_high;
   } req_type;

   // Result transfer payload.
   typedef struct packed {
      logic [63:0] plain_low;
      logic [63:0] plain_high;
   } rsp_type;

   // The four key words as seen by the datapath.
   typedef logic [NumKeys-1:0][31:0] key_array_type;

   // Four little-endian block words.
   typedef logic [3:0][31:0] word_array_type;

   // Rotation source table; each entry is XORed with RotMask before use.
   localparam logic [31:0][7:0] RotTable = {
      8'hB9, 8'hB1, 8'hA9, 8'hA1, 8'hBA, 8'hBB, 8'hB8, 8'hB9,
      8'hBE, 8'hBF, 8'hBC, 8'hB2, 8'hB3, 8'hB0, 8'hB1, 8'hB6,
      8'hB7, 8'hB4, 8'hAA, 8'hAB, 8'hA8, 8'hA9, 8'hAE, 8'hAF,
      8'hAC, 8'hA2, 8'hA3, 8'hA0, 8'hA1, 8'hA6, 8'hA7, 8'hA4
   };

   localparam logic [7:0] RotMask = 8'hA5;

   // Distance between the first and second rotation indexes of a word.
   localparam logic [4:0] SecondStep = 5'd12;

   // Rotation amount for a 5-bit table index; only the low five bits count.
   function automatic logic [4:0] rot_amount(input logic [4:0] idx);
      logic [7:0] entry;
      entry = RotTable[idx] ^ RotMask;
      return entry[4:0];
   endfunction

   // Rotate right by n.
   function automatic logic [31:0] rotr32(input logic [31:0] v, input logic [4:0] n);
      logic [63:0] wide;
      wide = {v, v} >> n;
      return wide[31:0];
   endfunction

   // Rotate left by n.
   function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
      logic [63:0] wide;
      wide = {v, v} << n;
      return wide[63:32];
   endfunction

endpackage

// ===== hdl/okbd_csr.sv =====
// ----------------------------------------------------------------------------
// okbd_csr: key register file
// Four 32-bit key words on a simple APB-style port with zero wait states.
// ----------------------------------------------------------------------------
module okbd_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [okbd_pkg::AddrWidth-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready,
   output okbd_pkg::key_array_type       key_words
);
   import okbd_pkg::*;

   key_array_type key_ff;
   key_array_type key_in;
   logic [1:0]    reg_idx;
   logic          write_en;

   // Word-aligned register select; byte lanes below it are ignored.
   assign reg_idx  = paddr[3:2];
   assign write_en = psel && penable && pwrite;

   // Next value of the key registers.
   always_comb begin
      key_in = key_ff;
      if (write_en) begin
         key_in[reg_idx] = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   // Reads return the addressed key word; the port never stalls.
   assign prdata    = key_ff[reg_idx];
   assign pready    = 1'b1;
   assign key_words = key_ff;

endmodule

// ===== hdl/okbd_unmask.sv =====
// ----------------------------------------------------------------------------
// okbd_unmask: byte unmasking
// XORs every byte but the selected one with the selected byte, then packs
// the block into four little-endian words.
// ----------------------------------------------------------------------------
module okbd_unmask (
   input  logic [63:0]              cipher_low,
   input  logic [63:0]              cipher_high,
   input  logic [3:0]               sel,
   output okbd_pkg::word_array_type words
);
   import okbd_pkg::*;

   logic [15:0][7:0] bytes_in;
   logic [15:0][7:0] bytes_out;
   logic [7:0]       mask_byte;

   // Byte 0 sits in the low bits of the low half.
   assign bytes_in  = {cipher_high, cipher_low};
   assign mask_byte = bytes_in[sel];

   // The selected byte passes through unchanged.
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         if (4'(i) == sel) begin
            bytes_out[i] = bytes_in[i];
         end else begin
            bytes_out[i] = bytes_in[i] ^ mask_byte;
         end
      end
   end

   assign words = bytes_out;

endmodule

// ===== hdl/okbd_lane.sv =====
// ----------------------------------------------------------------------------
// okbd_lane: word mixing lane
// Mixes one block word with its rotated key word and rotates the result.
// Even lanes rotate right, odd lanes rotate left.
// ----------------------------------------------------------------------------
module okbd_lane (
   input  logic [31:0] word_in,
   input  logic [31:0] key_word,
   input  logic [4:0]  amt_key,
   input  logic [4:0]  amt_out,
   input  logic        rot_left,
   output logic [31:0] word_out
);
   import okbd_pkg::*;

   logic [31:0] key_rot;
   logic [31:0] mixed;

   // Rotate the key, mix it in, then rotate the mixed word the same way.
   always_comb begin
      if (rot_left) begin
         key_rot  = rotl32(key_word, amt_key);
         mixed    = word_in ^ key_rot;
         word_out = rotl32(mixed, amt_out);
      end else begin
         key_rot  = rotr32(key_word, amt_key);
         mixed    = word_in ^ key_rot;
         word_out = rotr32(mixed, amt_out);
      end
   end

endmodule

// ===== hdl/offset_keyed_block_decrypt.sv =====
// A block taken into the input register moves on to the result register, which drives
// rsp_data, with rsp_valid high for a single cycle per result.
// Throughput: one block per cycle; busy is always low.
// The work sits between an input register and a result register.
// Reset (synchronous, active high) clears the key words and both valid flags.
// Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
// offset_keyed_block_decrypt: top level
// Two-stage decryptor for 16-byte blocks keyed by stream offset and key words.
// ----------------------------------------------------------------------------
module offset_keyed_block_decrypt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  okbd_pkg::req_type              req_data,
   output logic                           rsp_valid,
   output okbd_pkg::rsp_type              rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [okbd_pkg::AddrWidth-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);
   import okbd_pkg::*;

   key_array_type  key_words;
   req_type        req_ff;
   logic           stage_valid_ff;
   logic           stage_valid_in;
   rsp_type        rsp_ff;
   rsp_type        rsp_in;
   logic           rsp_valid_ff;
   word_array_type unmasked;
   word_array_type mixed;
   logic [4:0]     base_idx;

   // Key registers.
   okbd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .key_words (key_words)
   );

   // The block accepts a transfer in every cycle.
   assign busy           = 1'b0;
   assign stage_valid_in = start && !busy;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_valid_in) begin
         req_ff <= req_data;
      end
   end

   // Byte unmasking selected by offset bits 3..0.
   okbd_unmask u_unmask (
      .cipher_low  (req_ff.cipher_low),
      .cipher_high (req_ff.cipher_high),
      .sel         (req_ff.block_offset[3:0]),
      .words       (unmasked)
   );

   // Table index base comes from offset bits 8..4.
   assign base_idx = req_ff.block_offset[8:4];

   // One mixing lane per word; indexes wrap modulo 32.
   for (genvar g = 0; g < 4; g++) begin : g_lane
      logic [4:0] idx_key;
      logic [4:0] idx_out;

      assign idx_key = base_idx + 5'(3 * g);
      assign idx_out = idx_key + SecondStep;

      okbd_lane u_lane (
         .word_in  (unmasked[g]),
         .key_word (key_words[g]),
         .amt_key  (rot_amount(idx_key)),
         .amt_out  (rot_amount(idx_out)),
         .rot_left (1'(g % 2)),
         .word_out (mixed[g])
      );
   end

   assign rsp_in.plain_low  = {mixed[1], mixed[0]};
   assign rsp_in.plain_high = {mixed[3], mixed[2]};

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hdl/okbd_checker.sv =====
// ----------------------------------------------------------------------------
// okbd_checker: port-level checks for the block decryptor
// Watches the top-level ports for result timing and register behavior.
// ----------------------------------------------------------------------------
module okbd_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_valid,
   input logic                           psel,
   input logic                           penable,
   input logic                           pwrite,
   input logic [okbd_pkg::AddrWidth-1:0] paddr,
   input logic [31:0]                    pwdata,
   input logic [31:0]                    prdata,
   input logic                           pready
);
   import okbd_pkg::*;

   logic accept;
   logic cfg_write;

   assign accept    = start && !busy;
   assign cfg_write = psel && penable && pwrite && pready;

   // Every accepted transfer yields a result after the input and result registers.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_valid)
      else $error("accepted block produced no result");

   // No result appears without a matching earlier accepted transfer.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |-> ##2 !rsp_valid)
      else $error("result without an accepted block");

   // The block never holds off a request.
   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("busy asserted");

   // A written key word reads back at the same address in the next cycle.
   a_readback: assert property (@(posedge clock) disable iff (reset)
      cfg_write |=> (($stable(paddr)) ? (prdata == $past(pwdata)) : 1'b1))
      else $error("key register readback mismatch");

   // No result may appear in the cycle right after reset.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe set after reset");

endmodule

bind offset_keyed_block_decrypt okbd_checker u_okbd_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .psel      (psel),
   .penable   (penable),
   .pwrite    (pwrite),
   .paddr     (paddr),
   .pwdata    (pwdata),
   .prdata    (prdata),
   .pready    (pready)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for offset_keyed_block_decrypt
// Drives 16-byte cipher blocks with random gaps, loads several key settings
// through the register port, and compares every decrypted block against an
// independent prediction of the XOR and rotate datapath.
// ----------------------------------------------------------------------------
module testbench;

   import okbd_pkg::*;

   // Cycles without any transfer before the run is declared hung.
   localparam int unsigned IdleLimit = 200;

   // Random blocks per key setting and the number of key settings.
   localparam int unsigned BlocksPerSetting = 210;
   localparam int unsigned KeySettings      = 6;

   // Byte addresses of the key registers.
   typedef enum logic [AddrWidth-1:0] {
      KeyWord0Addr = 4'h0,
      KeyWord1Addr = 4'h4,
      KeyWord2Addr = 4'h8,
      KeyWord3Addr = 4'hC
   } key_addr_type;

   // Seed bytes of the shift schedule; each is XORed with 0xA5 and masked.
   localparam logic [0:31][7:0] ShiftSeed = {
      8'hA4, 8'hA7, 8'hA6, 8'hA1, 8'hA0, 8'hA3, 8'hA2, 8'hAC,
      8'hAF, 8'hAE, 8'hA9, 8'hA8, 8'hAB, 8'hAA, 8'hB4, 8'hB7,
      8'hB6, 8'hB1, 8'hB0, 8'hB3, 8'hB2, 8'hBC, 8'hBF, 8'hBE,
      8'hB9, 8'hB8, 8'hBB, 8'hBA, 8'hA1, 8'hA9, 8'hB1, 8'hB9
   };
   localparam logic [7:0] ShiftMask = 8'hA5;

   // Tracks the key words, predicts each plain block and checks the results.
   class plain_tracker;
      logic [31:0] key_word [4];
      rsp_type     pending_plain [$];
      int unsigned blocks_noted;
      int unsigned results_checked;
      int unsigned mismatch_count;

      function new();
         for (int i = 0; i < 4; i++) key_word[i] = '0;
         blocks_noted    = 0;
         results_checked = 0;
         mismatch_count  = 0;
      endfunction

      // A completed key register write.
      function void set_key(logic [AddrWidth-1:0] addr, logic [31:0] value);
         case (addr)
            KeyWord0Addr: key_word[0] = value;
            KeyWord1Addr: key_word[1] = value;
            KeyWord2Addr: key_word[2] = value;
            KeyWord3Addr: key_word[3] = value;
            default: ;
         endcase
      endfunction

      function logic [4:0] shift_of(logic [4:0] idx);
         logic [7:0] seed;
         seed = ShiftSeed[idx] ^ ShiftMask;
         return seed[4:0];
      endfunction

      function logic [31:0] spin_right(logic [31:0] v, logic [4:0] n);
         return (v >> n) | (v << (6'd32 - {1'b0, n}));
      endfunction

      function logic [31:0] spin_left(logic [31:0] v, logic [4:0] n);
         return (v << n) | (v >> (6'd32 - {1'b0, n}));
      endfunction

      // Byte XOR with the selected byte, then the per-word key mix and rotate.
      function rsp_type decrypt_block(req_type blk);
         logic [7:0]  bytes [16];
         logic [31:0] w [4];
         logic [3:0]  sel;
         logic [4:0]  slot;
         logic [4:0]  first_shift;
         logic [4:0]  second_shift;
         logic [7:0]  pad;
         rsp_type     plain;
         sel  = blk.block_offset[3:0];
         slot = blk.block_offset[8:4];
         for (int i = 0; i < 8; i++) begin
            bytes[i]     = blk.cipher_low[8*i +: 8];
            bytes[i + 8] = blk.cipher_high[8*i +: 8];
         end
         pad = bytes[sel];
         for (int i = 0; i < 16; i++) begin
            if (i != sel) bytes[i] = bytes[i] ^ pad;
         end
         for (int i = 0; i < 4; i++) begin
            w[i] = {bytes[4*i+3], bytes[4*i+2], bytes[4*i+1], bytes[4*i]};
            first_shift  = shift_of(slot + 5'(3 * i));
            second_shift = shift_of(slot + 5'd12 + 5'(3 * i));
            if (i % 2 == 0) begin
               w[i] = spin_right(w[i] ^ spin_right(key_word[i], first_shift), second_shift);
            end else begin
               w[i] = spin_left(w[i] ^ spin_left(key_word[i], first_shift), second_shift);
            end
         end
         plain.plain_low  = {w[1], w[0]};
         plain.plain_high = {w[3], w[2]};
         return plain;
      endfunction

      // An accepted input transfer.
      function void note_block(req_type blk);
         pending_plain.push_back(decrypt_block(blk));
         blocks_noted++;
      endfunction

      // An accepted result transfer.
      function void check_plain(rsp_type got);
         rsp_type want;
         if (pending_plain.size() == 0) begin
            $error("result with no block outstanding: plain_low %h plain_high %h",
                   got.plain_low, got.plain_high);
            mismatch_count++;
         end else begin
            want = pending_plain.pop_front();
            results_checked++;
            if (got.plain_low !== want.plain_low) begin
               $error("plain_low mismatch: expected %h actual %h",
                      want.plain_low, got.plain_low);
               mismatch_count++;
            end
            if (got.plain_high !== want.plain_high) begin
               $error("plain_high mismatch: expected %h actual %h",
                      want.plain_high, got.plain_high);
               mismatch_count++;
            end
         end
      endfunction
   endclass

   logic                 clock   = 1'b0;
   logic                 reset   = 1'b1;
   logic                 start   = 1'b0;
   req_type              req_data = '0;
   logic                 psel    = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite  = 1'b0;
   logic [AddrWidth-1:0] paddr   = '0;
   logic [31:0]          pwdata  = '0;
   logic                 busy;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic [31:0]          prdata;
   logic                 pready;

   plain_tracker tracker;
   int unsigned  idle_cycles = 0;

   offset_keyed_block_decrypt dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Observe every transfer at the rising edge that completes it.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) tracker.check_plain(rsp_data);
         if (start && !busy) tracker.note_block(req_data);
         if (psel && penable && pwrite && pready) tracker.set_key(paddr, pwdata);
      end
   end

   // Watchdog: too long without any transfer means the block is stuck.
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || (psel && penable && pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Present one block after a gap; returns at the falling edge after the transfer.
   task automatic send_block(input req_type blk, input int unsigned gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= blk;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // Register write: setup cycle, then access until pready.
   task automatic write_key(input key_addr_type addr, input logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= addr;
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Let every outstanding block come back, then idle for pipeline slack.
   task automatic wait_for_drain();
      start <= 1'b0;
      while (tracker.pending_plain.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic load_keys(input logic [31:0] k0, input logic [31:0] k1,
                            input logic [31:0] k2, input logic [31:0] k3);
      write_key(KeyWord0Addr, k0);
      write_key(KeyWord1Addr, k1);
      write_key(KeyWord2Addr, k2);
      write_key(KeyWord3Addr, k3);
   endtask

   function automatic logic [63:0] random_half();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic req_type random_block();
      req_type blk;
      blk.block_offset = ($urandom_range(0, 3) == 0) ? ($urandom & 32'h1FF) : $urandom;
      blk.cipher_low   = random_half();
      blk.cipher_high  = random_half();
      return blk;
   endfunction

   // Every selector with the even shift slots, field extremes and ignored offset bits.
   task automatic send_directed();
      req_type blk;
      for (int sel = 0; sel < 16; sel++) begin
         blk.block_offset = 32'((sel * 2) << 4) | 32'(sel);
         blk.cipher_low   = (sel == 0) ? '0 : (sel == 1) ? '1 : {$urandom, $urandom};
         blk.cipher_high  = (sel == 0) ? '0 : (sel == 1) ? '1 : {$urandom, $urandom};
         send_block(blk, 0);
      end
      blk = '{block_offset: 32'hFFFF_FFFF, cipher_low: '1, cipher_high: '1};
      send_block(blk, 0);
      blk = '{block_offset: 32'h0000_01F0, cipher_low: 64'hAA55_AA55_AA55_AA55,
              cipher_high: 64'h55AA_55AA_55AA_55AA};
      send_block(blk, 1);
      blk = '{block_offset: 32'hFFFF_FE00, cipher_low: 64'h0706_0504_0302_0100,
              cipher_high: 64'h0F0E_0D0C_0B0A_0908};
      send_block(blk, 0);
      blk = '{block_offset: 32'h8000_0000, cipher_low: 64'h8000_0000_0000_0001,
              cipher_high: 64'h0000_0001_8000_0000};
      send_block(blk, 0);
   endtask

   // Main sequence: directed blocks, then random blocks under each key setting.
   initial begin
      logic [31:0] keys [4];
      int unsigned gap;
      tracker = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int setting = 0; setting < KeySettings; setting++) begin
         case (setting)
            0: keys = '{32'h0, 32'h0, 32'h0, 32'h0};
            1: keys = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
            2: keys = '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555};
            3: keys = '{32'h0000_0001, 32'h8000_0000, 32'h0001_0000, 32'h0000_8000};
            default: keys = '{$urandom, $urandom, $urandom, $urandom};
         endcase
         wait_for_drain();
         load_keys(keys[0], keys[1], keys[2], keys[3]);
         if (setting == 0) send_directed();

         for (int n = 0; n < BlocksPerSetting; n++) begin
            // Back-to-back bursts alternate with random gaps.
            gap = (n % 64 < 16) ? 0 : $urandom_range(0, 9);
            send_block(random_block(), gap);
            // Now and then hold off until everything has come back.
            if (n % 100 == 99) wait_for_drain();
         end
      end

      wait_for_drain();
      repeat (8) @(negedge clock);
      $display("Summary: %0d blocks sent under %0d key settings, %0d results checked.",
               tracker.blocks_noted, KeySettings, tracker.results_checked);
      if (tracker.mismatch_count == 0 && tracker.pending_plain.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
